// File: rtl/edt_pkg.sv
// Shared constants, types and helpers for the distance transform block.
// Used by edt_line, edt_isqrt and euclidean_distance_transform; no dependencies.
package edt_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int LINE_LEN   = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam int IDX_W      = $clog2(LINE_LEN);
    localparam int DIM_W      = IDX_W + 1;
    localparam int ADDR_W     = 2 * IDX_W;
    localparam int COST_W     = 19;
    localparam int NUM_W      = 21;
    localparam int DEN_W      = 10;
    localparam int MB_W       = DEN_W + 1;
    localparam int PROD_W     = NUM_W + MB_W;
    localparam int OUT_W      = 17;
    localparam int ROOT_W     = 18;

    localparam logic [COST_W-1:0] SAT_COST = COST_W'(262144);
    localparam logic [OUT_W-1:0]  OUT_MAX  = OUT_W'(131071);

    // Request codes carried in the input tuser field.
    localparam logic [1:0] REQ_WRITE   = 2'd0;
    localparam logic [1:0] REQ_COMPUTE = 2'd1;
    localparam logic [1:0] REQ_READ    = 2'd2;

    // Configuration register indexes.
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    // Start command for the line unit.
    typedef struct packed {
        logic             start;
        logic [DIM_W-1:0] n;
    } t_line_ctl;

    // Cost load port of the line unit.
    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  addr;
        logic [COST_W-1:0] data;
    } t_cost_wr;

    // One finished sample of a line.
    typedef struct packed {
        logic              valid;
        logic [IDX_W-1:0]  idx;
        logic [COST_W-1:0] value;
    } t_line_res;

    // A zero dimension acts as one, an oversized one as the built maximum.
    function automatic logic [DIM_W-1:0] eff_dim(input logic [8:0] raw, input int maxv);
        logic [DIM_W-1:0] res;
        if (raw == 9'd0) begin
            res = DIM_W'(1);
        end else if (32'(raw) > maxv) begin
            res = DIM_W'(maxv);
        end else begin
            res = DIM_W'(raw);
        end
        return res;
    endfunction

endpackage

// File: rtl/edt_line.sv
// One-dimensional squared distance transform over a line of costs.
// Lower envelope of parabolas on one shared multiplier; depends on edt_pkg.
module edt_line (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  edt_pkg::t_line_ctl i_ctl,
    input  edt_pkg::t_cost_wr  i_cost_wr,
    output edt_pkg::t_line_res o_res,
    output logic              o_done
);
    import edt_pkg::*;

    typedef enum logic [3:0] {
        L_IDLE, L_QRD, L_QSQ, L_IRD, L_ICOST, L_IVV, L_INUM, L_IP1, L_IP2,
        L_ICMP, L_PUSH, L_PINIT, L_PRD, L_PMUL, L_PCHK, L_POUT
    } t_state;

    // Line scratch memories.
    logic [COST_W-1:0]       m_cost [LINE_LEN];
    logic [IDX_W-1:0]        m_vert [LINE_LEN];
    logic signed [NUM_W-1:0] m_bnum [LINE_LEN];
    logic [DEN_W-1:0]        m_bden [LINE_LEN];

    t_state                  r_state;
    logic [DIM_W-1:0]        r_n;
    logic [DIM_W-1:0]        r_q;
    logic [IDX_W-1:0]        r_k;
    logic [IDX_W-1:0]        r_last;
    logic [COST_W-1:0]       r_a;
    logic [COST_W-1:0]       r_b;
    logic [IDX_W-1:0]        r_v;
    logic signed [NUM_W-1:0] r_bn;
    logic [DEN_W-1:0]        r_bd;
    logic signed [NUM_W-1:0] r_num;
    logic [DEN_W-1:0]        r_den;
    logic signed [PROD_W-1:0] r_p1;
    logic signed [PROD_W-1:0] r_prod;
    logic [COST_W-1:0]       r_cost_rd;
    logic [IDX_W-1:0]        r_vert_rd;
    logic signed [NUM_W-1:0] r_bn_rd;
    logic [DEN_W-1:0]        r_bd_rd;
    t_line_res               r_res;
    logic                    r_done;

    logic [IDX_W-1:0]        cost_ra;
    logic [IDX_W-1:0]        bnd_ra;
    logic signed [NUM_W-1:0] ma;
    logic signed [MB_W-1:0]  mb;
    logic signed [PROD_W-1:0] w_prod;
    logic signed [IDX_W+1:0] w_dv;
    logic [COST_W:0]         w_d;
    logic signed [PROD_W-1:0] w_bn_ext;
    logic                    vert_we;
    logic [IDX_W-1:0]        vert_wa;
    logic [IDX_W-1:0]        vert_wd;
    logic [IDX_W-1:0]        w_k1;

    assign w_k1     = r_k + 1'b1;
    assign w_dv     = signed'({1'b0, r_q}) - signed'({2'b00, r_v});
    assign w_bn_ext = PROD_W'(r_bn);
    assign w_prod   = ma * mb;
    assign w_d      = {1'b0, r_cost_rd} + w_prod[COST_W:0];

    // Read addresses and operand selection for the shared multiplier.
    always_comb begin
        cost_ra = r_q[IDX_W-1:0];
        bnd_ra  = r_k;
        ma      = '0;
        mb      = '0;
        case (r_state)
            L_ICOST: cost_ra = r_vert_rd;
            L_PCHK:  cost_ra = r_v;
            L_PRD:   bnd_ra  = w_k1;
            default: ;
        endcase
        case (r_state)
            L_QSQ: begin
                ma = signed'(NUM_W'(r_q));
                mb = signed'(MB_W'(r_q));
            end
            L_IVV: begin
                ma = signed'(NUM_W'(r_v));
                mb = signed'(MB_W'(r_v));
            end
            L_IP1: begin
                ma = r_num;
                mb = signed'({1'b0, r_bd});
            end
            L_IP2: begin
                ma = r_bn;
                mb = signed'({1'b0, r_den});
            end
            L_PMUL: begin
                ma = signed'(NUM_W'(r_q));
                mb = signed'({1'b0, r_bd_rd});
            end
            L_POUT: begin
                ma = NUM_W'(w_dv);
                mb = MB_W'(w_dv);
            end
            default: ;
        endcase
    end

    // Vertex write: first vertex at start, later vertices at each push.
    always_comb begin
        vert_we = 1'b0;
        vert_wa = '0;
        vert_wd = '0;
        if (r_state == L_IDLE && i_ctl.start) begin
            vert_we = 1'b1;
        end else if (r_state == L_PUSH) begin
            vert_we = 1'b1;
            vert_wa = w_k1;
            vert_wd = r_q[IDX_W-1:0];
        end
    end

    // Scratch memories with registered reads.
    always_ff @(posedge i_clk) begin
        if (i_cost_wr.we) begin
            m_cost[i_cost_wr.addr] <= i_cost_wr.data;
        end
        if (vert_we) begin
            m_vert[vert_wa] <= vert_wd;
        end
        if (r_state == L_PUSH) begin
            m_bnum[w_k1] <= r_num;
            m_bden[w_k1] <= r_den;
        end
        r_cost_rd <= m_cost[cost_ra];
        r_vert_rd <= m_vert[r_k];
        r_bn_rd   <= m_bnum[bnd_ra];
        r_bd_rd   <= m_bden[bnd_ra];
    end

    // Sequencer: envelope build, then envelope walk.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= L_IDLE;
            r_res   <= '0;
            r_done  <= 1'b0;
            r_k     <= '0;
            r_q     <= '0;
            r_n     <= '0;
            r_last  <= '0;
        end else begin
            r_res.valid <= 1'b0;
            r_done      <= 1'b0;
            case (r_state)
                L_IDLE: begin
                    if (i_ctl.start) begin
                        r_n <= i_ctl.n;
                        r_k <= '0;
                        r_q <= DIM_W'(1);
                        r_state <= (i_ctl.n == DIM_W'(1)) ? L_PINIT : L_QRD;
                    end
                end
                L_QRD: r_state <= L_QSQ;
                L_QSQ: begin
                    r_a     <= r_cost_rd + w_prod[COST_W-1:0];
                    r_state <= L_IRD;
                end
                L_IRD: r_state <= L_ICOST;
                L_ICOST: begin
                    r_v     <= r_vert_rd;
                    r_bn    <= r_bn_rd;
                    r_bd    <= r_bd_rd;
                    r_state <= L_IVV;
                end
                L_IVV: begin
                    r_b     <= r_cost_rd + w_prod[COST_W-1:0];
                    r_state <= L_INUM;
                end
                L_INUM: begin
                    r_num   <= signed'(NUM_W'(r_a)) - signed'(NUM_W'(r_b));
                    r_den   <= {1'b0, r_q[IDX_W-1:0] - r_v, 1'b0};
                    r_state <= (r_k == '0) ? L_PUSH : L_IP1;
                end
                L_IP1: begin
                    r_p1    <= w_prod;
                    r_state <= L_IP2;
                end
                L_IP2: begin
                    r_prod  <= w_prod;
                    r_state <= L_ICMP;
                end
                L_ICMP: begin
                    // The new parabola hides the top vertex: pop it and retry.
                    if (r_p1 <= r_prod) begin
                        r_k     <= r_k - 1'b1;
                        r_state <= L_IRD;
                    end else begin
                        r_state <= L_PUSH;
                    end
                end
                L_PUSH: begin
                    r_k <= w_k1;
                    r_q <= r_q + 1'b1;
                    r_state <= (r_q + 1'b1 == r_n) ? L_PINIT : L_QRD;
                end
                L_PINIT: begin
                    r_last  <= r_k;
                    r_k     <= '0;
                    r_q     <= '0;
                    r_state <= L_PRD;
                end
                L_PRD: r_state <= L_PMUL;
                L_PMUL: begin
                    r_v     <= r_vert_rd;
                    r_bn    <= r_bn_rd;
                    r_prod  <= w_prod;
                    r_state <= L_PCHK;
                end
                L_PCHK: begin
                    // Advance while the next boundary lies left of this sample.
                    if (r_k < r_last && w_bn_ext < r_prod) begin
                        r_k     <= w_k1;
                        r_state <= L_PRD;
                    end else begin
                        r_state <= L_POUT;
                    end
                end
                L_POUT: begin
                    r_res.valid <= 1'b1;
                    r_res.idx   <= r_q[IDX_W-1:0];
                    r_res.value <= (w_d > {1'b0, SAT_COST}) ? SAT_COST : w_d[COST_W-1:0];
                    r_q <= r_q + 1'b1;
                    if (r_q + 1'b1 == r_n) begin
                        r_done  <= 1'b1;
                        r_state <= L_IDLE;
                    end else begin
                        r_state <= L_PRD;
                    end
                end
                default: r_state <= L_IDLE;
            endcase
        end
    end

    assign o_res  = r_res;
    assign o_done = r_done;

endmodule

// File: rtl/edt_isqrt.sv
// Bit-serial integer square root of a squared distance scaled by 2^16.
// One result bit per cycle; depends on edt_pkg.
module edt_isqrt (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [edt_pkg::COST_W-1:0] i_value,
    output logic                       o_done,
    output logic [edt_pkg::ROOT_W-1:0] o_root
);
    import edt_pkg::*;

    localparam int RAD_W = COST_W + 16;
    localparam int BIT_W = $clog2(ROOT_W);

    logic                  r_busy;
    logic                  r_done;
    logic [BIT_W-1:0]      r_bit;
    logic [RAD_W-1:0]      r_rad;
    logic [ROOT_W-1:0]     r_root;
    logic [ROOT_W-1:0]     w_trial;
    logic [2*ROOT_W-1:0]   w_sq;

    assign w_trial = r_root | (ROOT_W'(1) << r_bit);
    assign w_sq    = w_trial * w_trial;

    // Keep each trial bit whose square still fits under the radicand.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_bit  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_rad  <= {i_value, 16'd0};
                r_root <= '0;
                r_bit  <= BIT_W'(ROOT_W - 1);
            end else if (r_busy) begin
                if (w_sq <= (2*ROOT_W)'(r_rad)) begin
                    r_root <= w_trial;
                end
                if (r_bit == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_bit <= r_bit - 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

// File: rtl/euclidean_distance_transform.sv
// Top level of the Euclidean distance transform: grid memories, sequencer, ports.
// Depends on edt_pkg, edt_line and edt_isqrt.
//
// Channel   Direction  Contents
// s_axis    in         tuser request type; tdata cell_x, cell_y, obstacle
// m_axis    out        tuser done_kind; tdata sq_distance, distance_q8, no_obstacle
// APB       in/out     grid_width at 0x0, grid_height at 0x4
//
// A write, or a read off the grid or with no obstacle, skips to the done state;
// other reads wait on the 18-step square root. A compute, columns then rows, loads
// each line of n cells, then builds the envelope (vertex tests for each cell) and
// walks it (boundary steps plus one output per cell) on the one shared multiplier.
// Reset is synchronous; the grid and distance memories are not cleared.
// The input is not ready while an item is in work or waits for the output.
module euclidean_distance_transform (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input transaction.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // cell_x[7:0], cell_y[15:8], obstacle[16], zero pad
    input  logic [1:0]  s_axis_tuser,   // req_type[1:0]
    // Result transaction.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // sq_distance[16:0], distance_q8[33:17],
                                        // no_obstacle[34], zero pad
    output logic [1:0]  m_axis_tuser,   // done_kind[1:0]
    // Configuration.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import edt_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_RD_MEM, S_RD_SQRT, S_LOAD, S_LDRAIN, S_RUN, S_RWAIT, S_DONE
    } t_state;

    // Grid and distance memories.
    logic                    m_grid  [MAX_WIDTH*MAX_HEIGHT];
    logic [COST_W-1:0]       m_store [MAX_WIDTH*MAX_HEIGHT];

    t_state                  r_state;
    logic [8:0]              r_grid_width;
    logic [8:0]              r_grid_height;
    logic                    r_none;
    logic                    r_any;
    logic                    r_pass;
    logic [DIM_W-1:0]        r_line;
    logic [DIM_W-1:0]        r_i;
    logic                    r_ld_v;
    logic [IDX_W-1:0]        r_ld_idx;
    logic                    r_gr_rd;
    logic [COST_W-1:0]       r_st_rd;
    logic [1:0]              r_res_kind;
    logic [OUT_W-1:0]        r_res_sq;
    logic [OUT_W-1:0]        r_res_dq;
    logic                    r_res_no;
    logic                    r_m_valid;
    logic [OUT_W-1:0]        r_o_sq;
    logic [OUT_W-1:0]        r_o_dq;
    logic                    r_o_no;
    logic [1:0]              r_o_kind;

    logic [DIM_W-1:0]        w_w;
    logic [DIM_W-1:0]        w_h;
    logic [DIM_W-1:0]        w_n;
    logic [DIM_W-1:0]        w_lines;
    logic [IDX_W-1:0]        w_x;
    logic [IDX_W-1:0]        w_y;
    logic                    w_inside;
    logic                    w_accept;
    logic                    w_cfg_wr;
    logic [ADDR_W-1:0]       st_ra;
    logic [ADDR_W-1:0]       st_wa;
    logic [ADDR_W-1:0]       gr_ra;
    t_line_ctl               w_ctl;
    t_cost_wr                w_cost_wr;
    t_line_res               w_res;
    logic                    w_line_done;
    logic                    w_sq_done;
    logic [ROOT_W-1:0]       w_root;

    assign w_w      = eff_dim(r_grid_width, MAX_WIDTH);
    assign w_h      = eff_dim(r_grid_height, MAX_HEIGHT);
    assign w_n      = r_pass ? w_w : w_h;
    assign w_lines  = r_pass ? w_h : w_w;
    assign w_x      = s_axis_tdata[7:0];
    assign w_y      = s_axis_tdata[15:8];
    assign w_inside = ({1'b0, w_x} < w_w) && ({1'b0, w_y} < w_h);

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    // Configuration registers.
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;
    assign prdata   = (paddr[2] == REG_HEIGHT) ? {23'd0, r_grid_height} : {23'd0, r_grid_width};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= 9'd256;
            r_grid_height <= 9'd256;
        end else if (w_cfg_wr) begin
            if (paddr[2] == REG_WIDTH) begin
                r_grid_width <= pwdata[8:0];
            end else begin
                r_grid_height <= pwdata[8:0];
            end
        end
    end

    // Memory addresses: columns walk y, rows walk x.
    assign gr_ra = {r_i[IDX_W-1:0], r_line[IDX_W-1:0]};
    assign st_ra = (r_state == S_IDLE) ? {w_y, w_x} : {r_line[IDX_W-1:0], r_i[IDX_W-1:0]};
    assign st_wa = r_pass ? {r_line[IDX_W-1:0], w_res.idx} : {w_res.idx, r_line[IDX_W-1:0]};

    always_ff @(posedge i_clk) begin
        if (w_accept && s_axis_tuser == REQ_WRITE && w_inside) begin
            m_grid[{w_y, w_x}] <= s_axis_tdata[16];
        end
        if (w_res.valid) begin
            m_store[st_wa] <= w_res.value;
        end
        r_gr_rd <= m_grid[gr_ra];
        r_st_rd <= m_store[st_ra];
    end

    // Column costs: obstacle zero, free cell saturated; rows load stored results.
    assign w_cost_wr.we   = r_ld_v;
    assign w_cost_wr.addr = r_ld_idx;
    assign w_cost_wr.data = r_pass ? r_st_rd : (r_gr_rd ? '0 : SAT_COST);
    assign w_ctl.start    = (r_state == S_RUN);
    assign w_ctl.n        = w_n;

    edt_line u_line (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_ctl),
        .i_cost_wr (w_cost_wr),
        .o_res     (w_res),
        .o_done    (w_line_done)
    );

    edt_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_RD_MEM),
        .i_value (r_st_rd),
        .o_done  (w_sq_done),
        .o_root  (w_root)
    );

    // Request sequencer and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_none    <= 1'b1;
            r_any     <= 1'b0;
            r_pass    <= 1'b0;
            r_line    <= '0;
            r_i       <= '0;
            r_ld_v    <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_ld_v <= (r_state == S_LOAD);
            if (r_state == S_LOAD) begin
                r_ld_idx <= r_i[IDX_W-1:0];
            end
            if (r_ld_v && !r_pass && r_gr_rd) begin
                r_any <= 1'b1;
            end
            // The done state refills the output register itself.
            if (r_m_valid && m_axis_tready && r_state != S_DONE) begin
                r_m_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_res_kind <= s_axis_tuser;
                        r_res_sq   <= '0;
                        r_res_dq   <= '0;
                        r_res_no   <= 1'b0;
                        case (s_axis_tuser)
                            REQ_WRITE: r_state <= S_DONE;
                            REQ_COMPUTE: begin
                                r_pass  <= 1'b0;
                                r_line  <= '0;
                                r_i     <= '0;
                                r_any   <= 1'b0;
                                r_state <= S_LOAD;
                            end
                            REQ_READ: begin
                                if (!w_inside) begin
                                    r_state <= S_DONE;
                                end else if (r_none) begin
                                    r_res_sq <= OUT_MAX;
                                    r_res_dq <= OUT_MAX;
                                    r_res_no <= 1'b1;
                                    r_state  <= S_DONE;
                                end else begin
                                    r_state <= S_RD_MEM;
                                end
                            end
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                S_RD_MEM: begin
                    r_res_sq <= (r_st_rd > COST_W'(OUT_MAX)) ? OUT_MAX : r_st_rd[OUT_W-1:0];
                    r_state  <= S_RD_SQRT;
                end
                S_RD_SQRT: begin
                    if (w_sq_done) begin
                        r_res_dq <= (w_root > ROOT_W'(OUT_MAX)) ? OUT_MAX : w_root[OUT_W-1:0];
                        r_state  <= S_DONE;
                    end
                end
                S_LOAD: begin
                    r_i <= r_i + 1'b1;
                    if (r_i + 1'b1 == w_n) begin
                        r_state <= S_LDRAIN;
                    end
                end
                S_LDRAIN: r_state <= S_RUN;
                S_RUN:    r_state <= S_RWAIT;
                S_RWAIT: begin
                    if (w_line_done) begin
                        r_i <= '0;
                        if (r_line + 1'b1 == w_lines) begin
                            r_line <= '0;
                            if (!r_pass) begin
                                r_pass  <= 1'b1;
                                r_state <= S_LOAD;
                            end else begin
                                r_none   <= !r_any;
                                r_res_no <= !r_any;
                                r_state  <= S_DONE;
                            end
                        end else begin
                            r_line  <= r_line + 1'b1;
                            r_state <= S_LOAD;
                        end
                    end
                end
                S_DONE: begin
                    if (!r_m_valid || m_axis_tready) begin
                        r_m_valid <= 1'b1;
                        r_o_sq    <= r_res_sq;
                        r_o_dq    <= r_res_dq;
                        r_o_no    <= r_res_no;
                        r_o_kind  <= r_res_kind;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {5'd0, r_o_no, r_o_dq, r_o_sq};
    assign m_axis_tuser  = r_o_kind;

    // A line result is only written back while the sequencer waits on the line.
    a_res_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res.valid |-> r_state == S_RWAIT)
        else $error("line result outside of line wait");

    // The square root finishes only while a read waits on it.
    a_sqrt_in_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sq_done |-> r_state == S_RD_SQRT)
        else $error("square root result outside of read");

    // The done state loads the result whenever the output register has room.
    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_m_valid || m_axis_tready) && r_state == S_DONE |=> r_m_valid)
        else $error("pending result not taken into the output register");

    // A compute transaction starts loading at once, in the column pass.
    a_compute_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && s_axis_tuser == REQ_COMPUTE |=> r_state == S_LOAD && !r_pass)
        else $error("compute did not start with the column pass");

endmodule
